[hw/rtl/pfe_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types, sizes and codes of the palette fade engine.
// ----------------------------------------------------------------------------
package pfe_pkg;

  // Palette geometry
  localparam int ENTRIES   = 64;
  localparam int ENT_W     = $clog2(ENTRIES);
  localparam int DEPTH     = 2 * ENTRIES;      // main bank then second bank
  localparam int ADDR_W    = ENT_W + 1;
  localparam int CH_W      = 8;

  // Fade timing and channel levels
  localparam int LAST_FRAME = 21;
  localparam int FRAME_W    = $clog2(LAST_FRAME + 1);
  localparam int STEP_SIZE  = 32;
  localparam logic [CH_W-1:0]  STEP        = CH_W'(STEP_SIZE);
  localparam logic [CH_W-1:0]  WHITE_LEVEL = CH_W'(224);
  localparam logic [ENT_W-1:0] FULL_LAST   = ENT_W'(ENTRIES - 1);

  // Item kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;
  localparam logic [1:0] KIND_TICK  = 2'd3;

  // Fade kinds
  localparam logic [2:0] FADE_IDLE = 3'd0;
  localparam logic [2:0] FADE_IN   = 3'd1;
  localparam logic [2:0] FADE_OUT  = 3'd2;
  localparam logic [2:0] FLASH_IN  = 3'd3;
  localparam logic [2:0] FLASH_OUT = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_FIRST_ENTRY = 2'd0;
  localparam logic [1:0] CFG_ENTRY_SPAN  = 2'd1;
  localparam logic [1:0] CFG_SINGLE_BANK = 2'd2;

  // One palette color
  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } rgb_t;

endpackage

[hw/rtl/pfe_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pfe_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/pfe_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_step
// Per-entry fade step: moves one channel of a color by one step.
// ----------------------------------------------------------------------------
module pfe_step (
  input  logic [2:0]    mode,
  input  pfe_pkg::rgb_t cur,
  input  pfe_pkg::rgb_t tgt,
  output pfe_pkg::rgb_t nxt
);

  always_comb begin
    nxt = cur;
    case (mode)
      // raise blue, green, red toward target
      pfe_pkg::FADE_IN: begin
        if (cur != tgt) begin
          if (tgt.b > cur.b) begin
            nxt.b = pfe_pkg::CH_W'(cur.b + pfe_pkg::STEP);
          end else if (tgt.g > cur.g) begin
            nxt.g = pfe_pkg::CH_W'(cur.g + pfe_pkg::STEP);
          end else if (tgt.r > cur.r) begin
            nxt.r = pfe_pkg::CH_W'(cur.r + pfe_pkg::STEP);
          end
        end
      end
      // lower red, green, blue toward zero
      pfe_pkg::FADE_OUT: begin
        if (cur.r != '0) begin
          nxt.r = pfe_pkg::CH_W'(cur.r - pfe_pkg::STEP);
        end else if (cur.g != '0) begin
          nxt.g = pfe_pkg::CH_W'(cur.g - pfe_pkg::STEP);
        end else if (cur.b != '0) begin
          nxt.b = pfe_pkg::CH_W'(cur.b - pfe_pkg::STEP);
        end
      end
      // lower blue, green, red toward target
      pfe_pkg::FLASH_IN: begin
        if (cur != tgt) begin
          if (tgt.b < cur.b) begin
            nxt.b = pfe_pkg::CH_W'(cur.b - pfe_pkg::STEP);
          end else if (tgt.g < cur.g) begin
            nxt.g = pfe_pkg::CH_W'(cur.g - pfe_pkg::STEP);
          end else if (tgt.r < cur.r) begin
            nxt.r = pfe_pkg::CH_W'(cur.r - pfe_pkg::STEP);
          end
        end
      end
      // raise red, green, blue toward white
      pfe_pkg::FLASH_OUT: begin
        if (cur.r != pfe_pkg::WHITE_LEVEL) begin
          nxt.r = pfe_pkg::CH_W'(cur.r + pfe_pkg::STEP);
        end else if (cur.g != pfe_pkg::WHITE_LEVEL) begin
          nxt.g = pfe_pkg::CH_W'(cur.g + pfe_pkg::STEP);
        end else if (cur.b != pfe_pkg::WHITE_LEVEL) begin
          nxt.b = pfe_pkg::CH_W'(cur.b + pfe_pkg::STEP);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[hw/rtl/palette_fade_engine_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_fade_engine_core
// Two-bank palette memory with current/target copies and a frame fade engine.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; each item gives one
// result, shown for one cycle with out_valid, which the receiver must take.
// A write, a tick with no active fade, or a start of fade-out, flash-out,
// idle or an undefined kind keeps busy low; its result comes next cycle.
// A read holds busy in ST_READ, which registers the arrived RAM data as its
// result. Starting fade-in or flash-in fills the region of the main current
// bank, one entry per cycle, with busy high until the last region entry is
// written. A tick during an active fade does a read-modify-write of every
// region entry, one entry per cycle through the RAM pipeline, in the main
// bank and (unless single_bank skips it for fade-in or flash-in) the second
// bank; busy covers ST_TICK and ST_DRAIN. Reset needs no clearing pass:
// per-entry valid bits make unwritten entries read as zero.
// ----------------------------------------------------------------------------
module palette_fade_engine_core (
  input  logic                        clk,
  input  logic                        rst_n,
  // command channel
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_kind,
  input  logic [1:0]                  in_bank,
  input  logic [pfe_pkg::ENT_W-1:0]   in_entry,
  input  logic [pfe_pkg::CH_W-1:0]    in_red_in,
  input  logic [pfe_pkg::CH_W-1:0]    in_green_in,
  input  logic [pfe_pkg::CH_W-1:0]    in_blue_in,
  input  logic [2:0]                  in_fade_kind,
  // result channel
  output logic                        out_valid,
  output logic [pfe_pkg::CH_W-1:0]    out_red_out,
  output logic [pfe_pkg::CH_W-1:0]    out_green_out,
  output logic [pfe_pkg::CH_W-1:0]    out_blue_out,
  output logic                        out_done_res,
  // configuration channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [pfe_pkg::ENT_W-1:0]   cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_FILL,
    ST_TICK,
    ST_DRAIN
  } state_t;

  localparam int AW = pfe_pkg::ADDR_W;
  localparam int EW = pfe_pkg::ENT_W;
  localparam int FW = pfe_pkg::FRAME_W;

  state_t state_r, state_nxt;

  // configuration registers
  logic [EW-1:0] first_entry_r, entry_span_r;
  logic          single_bank_r;

  // fade state
  logic [2:0]    active_r, active_nxt;
  logic [FW-1:0] frame_r, frame_nxt;
  logic [EW-1:0] region_first_r, region_first_nxt;
  logic [EW-1:0] region_end_r, region_end_nxt;

  // sweep control
  logic [EW-1:0] idx_r, idx_nxt;
  logic          bank_r, bank_nxt;
  logic          fill_white_r, fill_white_nxt;
  logic          done_pend_r, done_pend_nxt;
  logic          rd_tgt_r, rd_tgt_nxt;
  logic          cur_hit_r, cur_hit_nxt;
  logic          tgt_hit_r, tgt_hit_nxt;
  logic          wb_vld_r, wb_vld_nxt;
  logic [AW-1:0] wb_addr_r, wb_addr_nxt;

  // per-entry valid bits (unwritten entries read as zero)
  logic [pfe_pkg::DEPTH-1:0] cur_vld_r, tgt_vld_r;

  // result registers
  logic                     out_valid_r, out_valid_nxt;
  pfe_pkg::rgb_t            out_rgb_r, out_rgb_nxt;
  logic                     out_done_r, out_done_nxt;

  // memory ports
  logic          cur_we, tgt_we;
  logic [AW-1:0] waddr, raddr;
  pfe_pkg::rgb_t wdata;
  pfe_pkg::rgb_t cur_rdata, tgt_rdata;
  pfe_pkg::rgb_t cur_eff, tgt_eff, step_out;

  logic [EW:0]   cfg_sum;
  logic [EW-1:0] cfg_end;
  logic          second_bank;

  pfe_ram #(
    .WIDTH ($bits(pfe_pkg::rgb_t)),
    .DEPTH (pfe_pkg::DEPTH)
  ) u_cur_ram (
    .clk   (clk),
    .we    (cur_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (cur_rdata)
  );

  pfe_ram #(
    .WIDTH ($bits(pfe_pkg::rgb_t)),
    .DEPTH (pfe_pkg::DEPTH)
  ) u_tgt_ram (
    .clk   (clk),
    .we    (tgt_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (tgt_rdata)
  );

  // mask reads of never-written entries
  assign cur_eff = cur_hit_r ? cur_rdata : '0;
  assign tgt_eff = tgt_hit_r ? tgt_rdata : '0;

  pfe_step u_step (
    .mode (active_r),
    .cur  (cur_eff),
    .tgt  (tgt_eff),
    .nxt  (step_out)
  );

  // fade-in region end, clipped to the last entry
  assign cfg_sum = {1'b0, first_entry_r} + {1'b0, entry_span_r};
  assign cfg_end = cfg_sum[EW] ? pfe_pkg::FULL_LAST : cfg_sum[EW-1:0];

  // second bank skipped for fade-in and flash-in in single-bank mode
  assign second_bank = !(((active_r == pfe_pkg::FADE_IN) || (active_r == pfe_pkg::FLASH_IN))
                         && single_bank_r);

  assign busy          = (state_r != ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_red_out   = out_rgb_r.r;
  assign out_green_out = out_rgb_r.g;
  assign out_blue_out  = out_rgb_r.b;
  assign out_done_res  = out_done_r;

  // sequencer and memory port control
  always_comb begin
    state_nxt        = state_r;
    active_nxt       = active_r;
    frame_nxt        = frame_r;
    region_first_nxt = region_first_r;
    region_end_nxt   = region_end_r;
    idx_nxt          = idx_r;
    bank_nxt         = bank_r;
    fill_white_nxt   = fill_white_r;
    done_pend_nxt    = done_pend_r;
    rd_tgt_nxt       = rd_tgt_r;
    wb_vld_nxt       = 1'b0;
    wb_addr_nxt      = wb_addr_r;
    out_valid_nxt    = 1'b0;
    out_rgb_nxt      = '0;
    out_done_nxt     = 1'b0;
    cur_we           = 1'b0;
    tgt_we           = 1'b0;
    waddr            = {bank_r, idx_r};
    wdata            = '0;
    raddr            = {bank_r, idx_r};

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (in_kind)
            pfe_pkg::KIND_WRITE: begin
              out_valid_nxt = 1'b1;
              waddr         = {in_bank[1], in_entry};
              wdata         = '{r: in_red_in, g: in_green_in, b: in_blue_in};
              if (in_bank[0]) begin
                tgt_we = 1'b1;
              end else begin
                cur_we = 1'b1;
              end
            end
            pfe_pkg::KIND_READ: begin
              raddr      = {in_bank[1], in_entry};
              rd_tgt_nxt = in_bank[0];
              state_nxt  = ST_READ;
            end
            pfe_pkg::KIND_START: begin
              out_valid_nxt = 1'b1;
              if (in_fade_kind <= pfe_pkg::FLASH_OUT) begin
                active_nxt = in_fade_kind;
                frame_nxt  = '0;
                case (in_fade_kind)
                  pfe_pkg::FADE_IN: begin
                    region_first_nxt = first_entry_r;
                    region_end_nxt   = cfg_end;
                    idx_nxt          = first_entry_r;
                    fill_white_nxt   = 1'b0;
                    state_nxt        = ST_FILL;
                  end
                  pfe_pkg::FLASH_IN: begin
                    region_first_nxt = '0;
                    region_end_nxt   = pfe_pkg::FULL_LAST;
                    idx_nxt          = '0;
                    fill_white_nxt   = 1'b1;
                    state_nxt        = ST_FILL;
                  end
                  pfe_pkg::FADE_OUT, pfe_pkg::FLASH_OUT: begin
                    region_first_nxt = '0;
                    region_end_nxt   = pfe_pkg::FULL_LAST;
                  end
                  default: begin
                  end
                endcase
              end
            end
            pfe_pkg::KIND_TICK: begin
              if ((active_r != pfe_pkg::FADE_IDLE) && (active_r <= pfe_pkg::FLASH_OUT)) begin
                if (frame_r == FW'(pfe_pkg::LAST_FRAME)) begin
                  frame_nxt     = '0;
                  done_pend_nxt = 1'b1;
                end else begin
                  frame_nxt     = FW'(frame_r + 1'b1);
                  done_pend_nxt = 1'b0;
                end
                idx_nxt   = region_first_r;
                bank_nxt  = 1'b0;
                state_nxt = ST_TICK;
              end else begin
                out_valid_nxt = 1'b1;
                out_done_nxt  = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // read data arrives from the RAMs this cycle
      ST_READ: begin
        out_valid_nxt = 1'b1;
        out_rgb_nxt   = rd_tgt_r ? tgt_eff : cur_eff;
        state_nxt     = ST_IDLE;
      end

      // fill the main current bank over the region
      ST_FILL: begin
        cur_we = 1'b1;
        waddr  = {1'b0, idx_r};
        wdata  = fill_white_r ? {3{pfe_pkg::WHITE_LEVEL}} : '0;
        if (idx_r == region_end_r) begin
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = EW'(idx_r + 1'b1);
        end
      end

      // issue reads; the write-back follows in the next cycle
      ST_TICK: begin
        wb_vld_nxt  = 1'b1;
        wb_addr_nxt = {bank_r, idx_r};
        if (idx_r == region_end_r) begin
          if (!bank_r && second_bank) begin
            bank_nxt = 1'b1;
            idx_nxt  = region_first_r;
          end else begin
            state_nxt = ST_DRAIN;
          end
        end else begin
          idx_nxt = EW'(idx_r + 1'b1);
        end
      end

      // last write-back, then report
      ST_DRAIN: begin
        out_valid_nxt = 1'b1;
        out_done_nxt  = done_pend_r;
        state_nxt     = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // tick write-back of the stepped entry
    if (wb_vld_r) begin
      cur_we = 1'b1;
      waddr  = wb_addr_r;
      wdata  = step_out;
    end

    cur_hit_nxt = cur_vld_r[raddr];
    tgt_hit_nxt = tgt_vld_r[raddr];
  end

  // state, registered outputs and valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      first_entry_r  <= '0;
      entry_span_r   <= pfe_pkg::FULL_LAST;
      single_bank_r  <= 1'b0;
      active_r       <= pfe_pkg::FADE_IDLE;
      frame_r        <= '0;
      region_first_r <= '0;
      region_end_r   <= pfe_pkg::FULL_LAST;
      wb_vld_r       <= 1'b0;
      out_valid_r    <= 1'b0;
      cur_vld_r      <= '0;
      tgt_vld_r      <= '0;
    end else begin
      state_r        <= state_nxt;
      active_r       <= active_nxt;
      frame_r        <= frame_nxt;
      region_first_r <= region_first_nxt;
      region_end_r   <= region_end_nxt;
      wb_vld_r       <= wb_vld_nxt;
      out_valid_r    <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          pfe_pkg::CFG_FIRST_ENTRY: first_entry_r <= cfg_data;
          pfe_pkg::CFG_ENTRY_SPAN:  entry_span_r  <= cfg_data;
          pfe_pkg::CFG_SINGLE_BANK: single_bank_r <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (cur_we) begin
        cur_vld_r[waddr] <= 1'b1;
      end
      if (tgt_we) begin
        tgt_vld_r[waddr] <= 1'b1;
      end
    end
    // payload registers
    idx_r        <= idx_nxt;
    bank_r       <= bank_nxt;
    fill_white_r <= fill_white_nxt;
    done_pend_r  <= done_pend_nxt;
    rd_tgt_r     <= rd_tgt_nxt;
    cur_hit_r    <= cur_hit_nxt;
    tgt_hit_r    <= tgt_hit_nxt;
    wb_addr_r    <= wb_addr_nxt;
    out_rgb_r    <= out_rgb_nxt;
    out_done_r   <= out_done_nxt;
  end

endmodule

[verif/palette_fade_engine_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_fade_engine_core_tb
// Self-checking bench for the palette fade engine: a directed table of
// entry transfers, fade starts and ticks, then phases of random fade
// sequences under changing region settings, checked against a palette model.
// ----------------------------------------------------------------------------
module palette_fade_engine_core_tb;

  localparam int DIR_ROWS = 25;
  localparam int RAND_ITEMS = 1120;

  // One command item as it goes onto the input ports
  typedef struct packed {
    logic [1:0]                kind;
    logic [1:0]                bank;
    logic [pfe_pkg::ENT_W-1:0] entry;
    pfe_pkg::rgb_t             color;
    logic [2:0]                fade;
  } cmd_t;

  // One result transfer
  typedef struct packed {
    pfe_pkg::rgb_t color;
    logic          done;
  } result_t;

  // Directed row: command plus an optional hand-written expectation
  typedef struct {
    logic [1:0]                kind;
    logic [1:0]                bank;
    logic [pfe_pkg::ENT_W-1:0] entry;
    pfe_pkg::rgb_t             color;
    logic [2:0]                fade;
    bit                        chk;
    pfe_pkg::rgb_t             exp_color;
    logic                      exp_done;
  } dir_row_t;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [1:0]                in_kind;
  logic [1:0]                in_bank;
  logic [pfe_pkg::ENT_W-1:0] in_entry;
  logic [pfe_pkg::CH_W-1:0]  in_red_in;
  logic [pfe_pkg::CH_W-1:0]  in_green_in;
  logic [pfe_pkg::CH_W-1:0]  in_blue_in;
  logic [2:0]                in_fade_kind;
  logic                      out_valid;
  logic [pfe_pkg::CH_W-1:0]  out_red_out;
  logic [pfe_pkg::CH_W-1:0]  out_green_out;
  logic [pfe_pkg::CH_W-1:0]  out_blue_out;
  logic                      out_done_res;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [1:0]                cfg_index;
  logic [pfe_pkg::ENT_W-1:0] cfg_data;

  palette_fade_engine_core DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_kind      (in_kind),
    .in_bank      (in_bank),
    .in_entry     (in_entry),
    .in_red_in    (in_red_in),
    .in_green_in  (in_green_in),
    .in_blue_in   (in_blue_in),
    .in_fade_kind (in_fade_kind),
    .out_valid    (out_valid),
    .out_red_out  (out_red_out),
    .out_green_out(out_green_out),
    .out_blue_out (out_blue_out),
    .out_done_res (out_done_res),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Palette model state
  pfe_pkg::rgb_t             cur_pal [0:pfe_pkg::DEPTH-1];
  pfe_pkg::rgb_t             tgt_pal [0:pfe_pkg::DEPTH-1];
  logic [2:0]                fade_sel;
  int                        frame_cnt;
  logic [pfe_pkg::ENT_W-1:0] reg_first;
  logic [pfe_pkg::ENT_W-1:0] reg_span;
  logic [pfe_pkg::ENT_W-1:0] set_first;
  logic [pfe_pkg::ENT_W-1:0] set_span;
  logic                      set_single;

  result_t  pending_results [$];
  dir_row_t dir_rows [DIR_ROWS];

  // Bench bookkeeping
  int      accepted;
  int      cfg_writes;
  int      mismatches;
  bit      typed_chk;
  result_t typed_res;
  bit      no_idle;
  int      n_ticks, n_done, n_reads, n_starts, n_settings, rand_items;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

  // Last entry of the active region, clipped to the palette
  function automatic int region_last();
    int last;
    last = int'(reg_first) + int'(reg_span);
    if (last > pfe_pkg::ENTRIES - 1) last = pfe_pkg::ENTRIES - 1;
    return last;
  endfunction

  function automatic void fill_main(logic [pfe_pkg::CH_W-1:0] level);
    for (int i = int'(reg_first); i <= region_last(); i++)
      cur_pal[i] = '{level, level, level};
  endfunction

  // Move one channel of one entry by a step, per fade direction
  function automatic pfe_pkg::rgb_t step_color(pfe_pkg::rgb_t c, pfe_pkg::rgb_t t,
                                               logic [2:0] f);
    case (f)
      pfe_pkg::FADE_IN: if (c != t) begin
        if (t.b > c.b) c.b = c.b + pfe_pkg::STEP;
        else if (t.g > c.g) c.g = c.g + pfe_pkg::STEP;
        else if (t.r > c.r) c.r = c.r + pfe_pkg::STEP;
      end
      pfe_pkg::FLASH_IN: if (c != t) begin
        if (t.b < c.b) c.b = c.b - pfe_pkg::STEP;
        else if (t.g < c.g) c.g = c.g - pfe_pkg::STEP;
        else if (t.r < c.r) c.r = c.r - pfe_pkg::STEP;
      end
      pfe_pkg::FADE_OUT: begin
        if (c.r != 0) c.r = c.r - pfe_pkg::STEP;
        else if (c.g != 0) c.g = c.g - pfe_pkg::STEP;
        else if (c.b != 0) c.b = c.b - pfe_pkg::STEP;
      end
      pfe_pkg::FLASH_OUT: begin
        if (c.r != pfe_pkg::WHITE_LEVEL) c.r = c.r + pfe_pkg::STEP;
        else if (c.g != pfe_pkg::WHITE_LEVEL) c.g = c.g + pfe_pkg::STEP;
        else if (c.b != pfe_pkg::WHITE_LEVEL) c.b = c.b + pfe_pkg::STEP;
      end
      default: ;
    endcase
    return c;
  endfunction

  function automatic void step_bank(int bank_sel);
    int idx;
    for (int i = int'(reg_first); i <= region_last(); i++) begin
      idx = bank_sel * pfe_pkg::ENTRIES + i;
      cur_pal[idx] = step_color(cur_pal[idx], tgt_pal[idx], fade_sel);
    end
  endfunction

  // Apply one command to the palette model and return its result
  function automatic result_t palette_result(cmd_t c);
    result_t res;
    int idx;
    res = '0;
    idx = int'(c.bank[1]) * pfe_pkg::ENTRIES + int'(c.entry);
    case (c.kind)
      pfe_pkg::KIND_WRITE: begin
        if (c.bank[0]) tgt_pal[idx] = c.color;
        else cur_pal[idx] = c.color;
      end
      pfe_pkg::KIND_READ: res.color = c.bank[0] ? tgt_pal[idx] : cur_pal[idx];
      pfe_pkg::KIND_START: if (c.fade <= pfe_pkg::FLASH_OUT) begin
        if (c.fade == pfe_pkg::FADE_IN) begin
          reg_first = set_first;
          reg_span = set_span;
          fill_main('0);
        end else if (c.fade != pfe_pkg::FADE_IDLE) begin
          reg_first = '0;
          reg_span = pfe_pkg::FULL_LAST;
          if (c.fade == pfe_pkg::FLASH_IN) fill_main(pfe_pkg::WHITE_LEVEL);
        end
        fade_sel = c.fade;
        frame_cnt = 0;
      end
      default: begin
        if (fade_sel >= pfe_pkg::FADE_IN && fade_sel <= pfe_pkg::FLASH_OUT) begin
          step_bank(0);
          if (!((fade_sel == pfe_pkg::FADE_IN || fade_sel == pfe_pkg::FLASH_IN)
                && set_single))
            step_bank(1);
          frame_cnt++;
          if (frame_cnt > pfe_pkg::LAST_FRAME) begin
            frame_cnt = 0;
            res.done = 1'b1;
          end
        end else begin
          res.done = 1'b1;
        end
      end
    endcase
    return res;
  endfunction

  // Result check, register writes and command transfers, all at the rising edge
  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    cmd_t    c;
    if (rst_n) begin
      if (out_valid) begin
        got = '{'{out_red_out, out_green_out, out_blue_out}, out_done_res};
        if (got.done) n_done++;
        if (pending_results.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result %h/%h/%h done %b", $realtime,
                     got.color.r, got.color.g, got.color.b, got.done);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (got.color.r != want.color.r || got.color.g != want.color.g ||
              got.color.b != want.color.b || got.done != want.done) begin
            if (mismatches < 10)
              $display("%0t: result mismatch exp %h/%h/%h done %b, got %h/%h/%h done %b",
                       $realtime, want.color.r, want.color.g, want.color.b, want.done,
                       got.color.r, got.color.g, got.color.b, got.done);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pfe_pkg::CFG_FIRST_ENTRY: set_first = cfg_data;
          pfe_pkg::CFG_ENTRY_SPAN:  set_span = cfg_data;
          pfe_pkg::CFG_SINGLE_BANK: set_single = cfg_data[0];
          default: ;
        endcase
        cfg_writes++;
      end
      if (start && !busy) begin
        c = '{in_kind, in_bank, in_entry, '{in_red_in, in_green_in, in_blue_in},
              in_fade_kind};
        want = palette_result(c);
        pending_results.push_back(typed_chk ? typed_res : want);
        if (c.kind == pfe_pkg::KIND_TICK) n_ticks++;
        if (c.kind == pfe_pkg::KIND_READ) n_reads++;
        if (c.kind == pfe_pkg::KIND_START) n_starts++;
        accepted++;
      end
    end
  end

  // Idle time after a transfer: mostly none or short, now and then long
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (no_idle || p < 40) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Called at a falling edge; returns at a falling edge after the transfer and any gap
  task automatic send_cmd(cmd_t c, bit chk, result_t res);
    int seen;
    int gap;
    seen = accepted;
    in_kind = c.kind;
    in_bank = c.bank;
    in_entry = c.entry;
    in_red_in = c.color.r;
    in_green_in = c.color.g;
    in_blue_in = c.color.b;
    in_fade_kind = c.fade;
    typed_chk = chk;
    typed_res = res;
    start = 1'b1;
    do @(negedge clk); while (accepted == seen);
    gap = pick_gap();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_rand(cmd_t c);
    send_cmd(c, 1'b0, '0);
    rand_items++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [pfe_pkg::ENT_W-1:0] data);
    int seen;
    seen = cfg_writes;
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(negedge clk); while (cfg_writes == seen);
    cfg_valid = 1'b0;
  endtask

  // Hold off until every result is back and the engine has gone quiet
  task automatic wait_drained();
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic pfe_pkg::rgb_t pick_color();
    pfe_pkg::rgb_t c;
    c.r = ($urandom_range(0, 1) != 0) ? pfe_pkg::CH_W'($urandom_range(0, 7) * 32)
                                      : pfe_pkg::CH_W'($urandom);
    c.g = ($urandom_range(0, 1) != 0) ? pfe_pkg::CH_W'($urandom_range(0, 7) * 32)
                                      : pfe_pkg::CH_W'($urandom);
    c.b = ($urandom_range(0, 1) != 0) ? pfe_pkg::CH_W'($urandom_range(0, 7) * 32)
                                      : pfe_pkg::CH_W'($urandom);
    return c;
  endfunction

  // Entries mostly inside the configured region
  function automatic logic [pfe_pkg::ENT_W-1:0] pick_entry();
    int last;
    last = int'(set_first) + int'(set_span);
    if (last > pfe_pkg::ENTRIES - 1) last = pfe_pkg::ENTRIES - 1;
    if ($urandom_range(0, 99) < 60)
      return pfe_pkg::ENT_W'($urandom_range(int'(set_first), last));
    return pfe_pkg::ENT_W'($urandom);
  endfunction

  function automatic cmd_t noise_cmd();
    cmd_t c;
    c.kind = 2'($urandom);
    c.bank = 2'($urandom);
    c.entry = pfe_pkg::ENT_W'($urandom);
    c.color = pfe_pkg::rgb_t'(24'($urandom));
    c.fade = 3'($urandom);
    return c;
  endfunction

  function automatic cmd_t simple_cmd(logic [1:0] kind, logic [2:0] fade);
    cmd_t c;
    c = noise_cmd();
    c.kind = kind;
    c.fade = fade;
    if (kind == pfe_pkg::KIND_WRITE || kind == pfe_pkg::KIND_READ) c.entry = pick_entry();
    if (kind == pfe_pkg::KIND_WRITE) c.color = pick_color();
    return c;
  endfunction

  // Mostly a well-formed fade: load colors, start, ticks amid reads and writes
  task automatic run_sequence();
    int p;
    logic [2:0] fk;
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(3, 8)) send_rand(noise_cmd());
    end else begin
      repeat ($urandom_range(2, 10))
        send_rand(simple_cmd(pfe_pkg::KIND_WRITE, pfe_pkg::FADE_IDLE));
      p = $urandom_range(0, 99);
      if (p < 90)
        fk = 3'($urandom_range(int'(pfe_pkg::FADE_IN), int'(pfe_pkg::FLASH_OUT)));
      else if (p < 95) fk = pfe_pkg::FADE_IDLE;
      else fk = 3'($urandom_range(5, 7));
      send_rand(simple_cmd(pfe_pkg::KIND_START, fk));
      repeat ($urandom_range(5, 30)) begin
        p = $urandom_range(0, 99);
        if (p < 65) send_rand(simple_cmd(pfe_pkg::KIND_TICK, pfe_pkg::FADE_IDLE));
        else if (p < 85) send_rand(simple_cmd(pfe_pkg::KIND_READ, pfe_pkg::FADE_IDLE));
        else if (p < 95) send_rand(simple_cmd(pfe_pkg::KIND_WRITE, pfe_pkg::FADE_IDLE));
        else send_rand(noise_cmd());
      end
    end
  endtask

  initial begin : stimulus
    int phase_end;
    int phase;
    int guard;
    logic [pfe_pkg::ENT_W-1:0] first_v, span_v;
    logic                      single_v;
    result_t                   row_res;
    cmd_t                      row_cmd;

    start = 1'b0;
    in_kind = pfe_pkg::KIND_WRITE;
    in_bank = '0;
    in_entry = '0;
    in_red_in = '0;
    in_green_in = '0;
    in_blue_in = '0;
    in_fade_kind = pfe_pkg::FADE_IDLE;
    cfg_valid = 1'b0;
    cfg_index = pfe_pkg::CFG_FIRST_ENTRY;
    cfg_data = '0;
    typed_chk = 1'b0;
    typed_res = '0;
    no_idle = 1'b0;
    accepted = 0;
    cfg_writes = 0;
    mismatches = 0;
    n_ticks = 0;
    n_done = 0;
    n_reads = 0;
    n_starts = 0;
    n_settings = 0;
    rand_items = 0;

    // Model state after reset
    for (int i = 0; i < pfe_pkg::DEPTH; i++) begin
      cur_pal[i] = '0;
      tgt_pal[i] = '0;
    end
    fade_sel = pfe_pkg::FADE_IDLE;
    frame_cnt = 0;
    reg_first = '0;
    reg_span = pfe_pkg::FULL_LAST;
    set_first = '0;
    set_span = pfe_pkg::FULL_LAST;
    set_single = 1'b0;

    dir_rows = '{
      // reset contents and idle tick
      '{pfe_pkg::KIND_READ,  2'd0, 6'd0,  24'h000000, pfe_pkg::FADE_IDLE, 1'b1, 24'h000000, 1'b0},
      '{pfe_pkg::KIND_READ,  2'd3, 6'd63, 24'h000000, pfe_pkg::FADE_IDLE, 1'b1, 24'h000000, 1'b0},
      '{pfe_pkg::KIND_TICK,  2'd0, 6'd0,  24'h000000, pfe_pkg::FADE_IDLE, 1'b1, 24'h000000, 1'b1},
      // write each bank copy, reading back the main current and second target
      '{pfe_pkg::KIND_WRITE, 2'd0, 6'd63, 24'hffffff, pfe_pkg::FADE_IDLE, 1'b1, 24'h000000, 1'b0},
      '{pfe_pkg::KIND_READ,  2'd0, 6'd63, 24'h000000, pfe_pkg::FADE_IDLE, 1'b1, 24'hffffff, 1'b0},
      '{pfe_pkg::KIND_WRITE, 2'd3, 6'd0,  24'ha55a3c, pfe_pkg::FADE_IDLE, 1'b1, 24'h000000, 1'b0},
      '{pfe_pkg::KIND_READ,  2'd3, 6'd0,  24'h000000, pfe_pkg::FADE_IDLE, 1'b1, 24'ha55a3c, 1'b0},
      '{pfe_pkg::KIND_WRITE, 2'd2, 6'd42, 24'h00ff00, pfe_pkg::FADE_IDLE, 1'b1, 24'h000000, 1'b0},
      '{pfe_pkg::KIND_WRITE, 2'd1, 6'd21, 24'h80c0e0, pfe_pkg::FADE_IDLE, 1'b1, 24'h000000, 1'b0},
      // undefined fade kinds are dropped and ticks stay done; then an idle start
      '{pfe_pkg::KIND_START, 2'd0, 6'd0,  24'h000000, 3'd5,               1'b1, 24'h000000, 1'b0},
      '{pfe_pkg::KIND_START, 2'd0, 6'd0,  24'h000000, 3'd7,               1'b1, 24'h000000, 1'b0},
      '{pfe_pkg::KIND_TICK,  2'd0, 6'd0,  24'h000000, pfe_pkg::FADE_IDLE, 1'b1, 24'h000000, 1'b1},
      '{pfe_pkg::KIND_START, 2'd0, 6'd0,  24'h000000, pfe_pkg::FADE_IDLE, 1'b1, 24'h000000, 1'b0},
      // fade-in clears the main current bank
      '{pfe_pkg::KIND_START, 2'd0, 6'd0,  24'h000000, pfe_pkg::FADE_IN,   1'b1, 24'h000000, 1'b0},
      '{pfe_pkg::KIND_READ,  2'd0, 6'd63, 24'h000000, pfe_pkg::FADE_IDLE, 1'b1, 24'h000000, 1'b0},
      '{pfe_pkg::KIND_TICK,  2'd0, 6'd0,  24'h000000, pfe_pkg::FADE_IDLE, 1'b0, 24'h000000, 1'b0},
      '{pfe_pkg::KIND_READ,  2'd0, 6'd21, 24'h000000, pfe_pkg::FADE_IDLE, 1'b0, 24'h000000, 1'b0},
      '{pfe_pkg::KIND_READ,  2'd2, 6'd42, 24'h000000, pfe_pkg::FADE_IDLE, 1'b0, 24'h000000, 1'b0},
      // flash-in whitens the main bank, then fade-out and flash-out each get a tick
      '{pfe_pkg::KIND_START, 2'd0, 6'd0,  24'h000000, pfe_pkg::FLASH_IN,  1'b1, 24'h000000, 1'b0},
      '{pfe_pkg::KIND_READ,  2'd0, 6'd5,  24'h000000, pfe_pkg::FADE_IDLE, 1'b1, 24'he0e0e0, 1'b0},
      '{pfe_pkg::KIND_TICK,  2'd0, 6'd0,  24'h000000, pfe_pkg::FADE_IDLE, 1'b0, 24'h000000, 1'b0},
      '{pfe_pkg::KIND_START, 2'd0, 6'd0,  24'h000000, pfe_pkg::FADE_OUT,  1'b1, 24'h000000, 1'b0},
      '{pfe_pkg::KIND_TICK,  2'd0, 6'd0,  24'h000000, pfe_pkg::FADE_IDLE, 1'b0, 24'h000000, 1'b0},
      '{pfe_pkg::KIND_START, 2'd0, 6'd0,  24'h000000, pfe_pkg::FLASH_OUT, 1'b1, 24'h000000, 1'b0},
      '{pfe_pkg::KIND_TICK,  2'd0, 6'd0,  24'h000000, pfe_pkg::FADE_IDLE, 1'b0, 24'h000000, 1'b0}
    };

    // Synchronous reset, once
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Unused register index is ignored
    write_reg(2'd3, '1);

    // Directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      row_cmd = '{dir_rows[i].kind, dir_rows[i].bank, dir_rows[i].entry,
                  dir_rows[i].color, dir_rows[i].fade};
      row_res = '{dir_rows[i].exp_color, dir_rows[i].exp_done};
      send_cmd(row_cmd, dir_rows[i].chk, row_res);
    end

    // Random phases, each under its own region setting
    phase = 0;
    while (rand_items < RAND_ITEMS) begin
      wait_drained();
      case (phase)
        0: begin
          first_v = '0; span_v = pfe_pkg::FULL_LAST; single_v = 1'b0;
        end
        1: begin
          first_v = pfe_pkg::FULL_LAST; span_v = pfe_pkg::FULL_LAST; single_v = 1'b1;
        end
        2: begin
          first_v = '0; span_v = '0; single_v = 1'b1;
        end
        3: begin
          first_v = pfe_pkg::FULL_LAST; span_v = '0; single_v = 1'b0;
        end
        4: begin
          first_v = 6'd40; span_v = pfe_pkg::FULL_LAST; single_v = 1'b1;
        end
        default: begin
          first_v = pfe_pkg::ENT_W'($urandom);
          span_v = ($urandom_range(0, 3) == 0) ? pfe_pkg::ENT_W'($urandom_range(0, 3))
                                               : pfe_pkg::ENT_W'($urandom);
          single_v = 1'($urandom);
        end
      endcase
      write_reg(pfe_pkg::CFG_FIRST_ENTRY, first_v);
      write_reg(pfe_pkg::CFG_ENTRY_SPAN, span_v);
      // upper data bits of the single-bank flag are don't care
      write_reg(pfe_pkg::CFG_SINGLE_BANK,
                (pfe_pkg::ENT_W'($urandom) & ~pfe_pkg::ENT_W'(1)) | pfe_pkg::ENT_W'(single_v));
      n_settings++;
      no_idle = (phase % 4 == 3);
      phase_end = rand_items + 90;
      while (rand_items < phase_end && rand_items < RAND_ITEMS) run_sequence();
      phase++;
    end

    // Drain and let the engine settle
    start = 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    repeat (140) @(negedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d expected results never arrived", pending_results.size());
      mismatches++;
    end

    $display("Covered %0d commands (%0d ticks, %0d reads, %0d fade starts)",
             accepted, n_ticks, n_reads, n_starts);
    $display("  over %0d region settings; %0d done reports, %0d mismatches",
             n_settings, n_done, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[palette_fade_engine_core.f]
hw/rtl/pfe_pkg.sv
hw/rtl/pfe_ram.sv
hw/rtl/pfe_step.sv
hw/rtl/palette_fade_engine_core.sv
verif/palette_fade_engine_core_tb.sv
